### sv/stack_machine_execute_unit_assert.svh
// Assertion macros for the stack machine execute unit.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/sme_pkg.sv
// Shared types and codes for the stack machine execute unit.
// No dependencies; imported by every other file but the assert header.
`default_nettype none

package sme_pkg;

    localparam logic [3:0] OP_LD  = 4'd0;
    localparam logic [3:0] OP_ST  = 4'd1;
    localparam logic [3:0] OP_LDC = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd3;
    localparam logic [3:0] OP_SUB = 4'd4;
    localparam logic [3:0] OP_CMP = 4'd5;
    localparam logic [3:0] OP_JMP = 4'd6;
    localparam logic [3:0] OP_BR  = 4'd7;
    localparam logic [3:0] OP_HLT = 4'd8;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_END   = 3'd2;
    localparam logic [2:0] ST_UNDER = 3'd3;
    localparam logic [2:0] ST_OVER  = 3'd4;
    localparam logic [2:0] ST_ADDR  = 3'd5;

    typedef enum logic [2:0] {
        K_LD, K_ST, K_LDC, K_ALU, K_JMP, K_BR, K_HLT, K_NOP
    } t_op_kind;

    typedef enum logic [1:0] {
        ALU_ADD, ALU_SUB, ALU_CMP
    } t_alu_sel;

    typedef enum logic {
        EX_ISSUE, EX_EXEC
    } t_ex_state;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_value;
        logic [9:0]         jump_target;
        logic [9:0]         current_pc;
    } t_in_item;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic [8:0]         stack_count;
    } t_out_item;

    typedef struct packed {
        t_op_kind    kind;
        t_alu_sel    alu;
        logic        addr_ok;
        logic [31:0] value;
        logic [9:0]  target;
        logic [9:0]  pc;
    } t_dec_item;

endpackage

`default_nettype wire

### sv/sme_chan_if.sv
// Valid/ready channel interfaces for instruction and result beats.
// Depends on sme_pkg for the payload types.
`default_nettype none

interface sme_in_if;
    import sme_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sme_out_if;
    import sme_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/sme_front.sv
// Front end: accepts instruction beats and classifies them for the queue.
// Depends on sme_pkg and sme_in_if.
`default_nettype none

module sme_front #(
    parameter int DATA_DEPTH = 1024
) (
    sme_in_if.sink           i_cmd,
    input  logic             i_q_full,
    input  logic             i_hold,
    output logic             o_push,
    output sme_pkg::t_dec_item o_item
);
    import sme_pkg::*;

    t_op_kind kind;
    t_alu_sel alu;

    assign i_cmd.ready = !i_q_full && !i_hold;
    assign o_push      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        kind = K_NOP;
        alu  = ALU_ADD;
        unique case (i_cmd.data.func)
            OP_LD:  kind = K_LD;
            OP_ST:  kind = K_ST;
            OP_LDC: kind = K_LDC;
            OP_ADD: begin
                kind = K_ALU;
                alu  = ALU_ADD;
            end
            OP_SUB: begin
                kind = K_ALU;
                alu  = ALU_SUB;
            end
            OP_CMP: begin
                kind = K_ALU;
                alu  = ALU_CMP;
            end
            OP_JMP: kind = K_JMP;
            OP_BR:  kind = K_BR;
            OP_HLT: kind = K_HLT;
            default: kind = K_NOP;
        endcase
    end

    always_comb begin
        o_item.kind    = kind;
        o_item.alu     = alu;
        o_item.addr_ok = !i_cmd.data.operand_value[31] &&
                         (i_cmd.data.operand_value < 32'(DATA_DEPTH));
        o_item.value   = i_cmd.data.operand_value;
        o_item.target  = i_cmd.data.jump_target;
        o_item.pc      = i_cmd.data.current_pc;
    end

endmodule

`default_nettype wire

### sv/sme_queue.sv
// Two-entry queue of decoded instructions between front and back.
// Depends on sme_pkg.
`default_nettype none

module sme_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sme_pkg::t_dec_item i_item,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output sme_pkg::t_dec_item o_item
);
    import sme_pkg::*;

    t_dec_item  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/sme_back.sv
// Back end: executes decoded instructions against the stack and data RAMs.
// Depends on sme_pkg and sme_out_if; holds the result register.
`default_nettype none

module sme_back #(
    parameter int DATA_DEPTH  = 1024,
    parameter int STACK_DEPTH = 256,
    parameter int PROG_DEPTH  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [10:0]        i_prog_len,
    input  logic               i_q_valid,
    input  sme_pkg::t_dec_item i_q_item,
    output logic               o_q_pop,
    output logic               o_clr_busy,
    sme_out_if.source          o_res
);
    import sme_pkg::*;

    localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [31:0]    r_dmem [DATA_DEPTH];
    logic [31:0]    r_smem [STACK_DEPTH];
    logic [31:0]    r_dmem_q;
    logic [31:0]    r_smem_q;

    t_ex_state      r_state, n_state;
    t_dec_item      r_cur;
    logic [SPW-1:0] r_sp, n_sp;
    logic [31:0]    r_tos, n_tos;
    logic           r_stopped;
    logic           r_clr_busy;
    logic [DAW-1:0] r_clr_idx;
    logic           r_out_valid;
    t_out_item      r_out;

    logic           out_free;
    logic           issue_go;
    logic           exec_go;
    logic           commit;
    logic [SPW-1:0] sp_m1;
    logic [SPW-1:0] sp_m2;
    logic           sp_full;
    logic [31:0]    lim;
    logic [31:0]    alu_res;
    logic [10:0]    nxt;
    logic [2:0]     sts;
    logic           err;
    logic           do_push;
    logic           do_pop;
    logic           do_alu;
    logic           do_st;
    logic [31:0]    push_val;
    logic           dmem_we;
    logic [DAW-1:0] dmem_wa;
    logic [31:0]    dmem_wd;
    logic           smem_we;

    assign out_free   = !r_out_valid || o_res.ready;
    assign o_clr_busy = r_clr_busy;
    assign sp_m1      = r_sp - SPW'(1);
    assign sp_m2      = r_sp - SPW'(2);
    assign sp_full    = (r_sp == SPW'(STACK_DEPTH));
    assign lim        = ({21'd0, i_prog_len} > 32'(PROG_DEPTH)) ?
                        32'(PROG_DEPTH) : {21'd0, i_prog_len};

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EX_ISSUE: if (!r_clr_busy && i_q_valid) n_state = EX_EXEC;
            EX_EXEC:  if (out_free) n_state = EX_ISSUE;
            default:  n_state = EX_ISSUE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        issue_go = 1'b0;
        exec_go  = 1'b0;
        unique case (r_state)
            EX_ISSUE: issue_go = !r_clr_busy && i_q_valid;
            EX_EXEC:  exec_go  = out_free;
            default: begin
                issue_go = 1'b0;
                exec_go  = 1'b0;
            end
        endcase
    end

    assign o_q_pop = issue_go;

    always_comb begin
        case (r_cur.alu)
            ALU_ADD: alu_res = r_tos + r_smem_q;
            ALU_SUB: alu_res = r_tos - r_smem_q;
            default: begin
                if (r_tos == r_smem_q) begin
                    alu_res = 32'd0;
                end else if ($signed(r_tos) < $signed(r_smem_q)) begin
                    alu_res = '1;
                end else begin
                    alu_res = 32'd1;
                end
            end
        endcase
    end

    always_comb begin
        nxt      = 11'(r_cur.pc) + 11'd1;
        sts      = ST_RUN;
        err      = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_alu   = 1'b0;
        do_st    = 1'b0;
        push_val = r_cur.value;
        if (r_stopped) begin
            nxt = 11'(r_cur.pc);
            sts = ST_HALT;
        end else begin
            unique case (r_cur.kind)
                K_LD: begin
                    if (!r_cur.addr_ok) sts = ST_ADDR;
                    else if (sp_full) sts = ST_OVER;
                    else begin
                        do_push  = 1'b1;
                        push_val = r_dmem_q;
                    end
                end
                K_ST: begin
                    if (!r_cur.addr_ok) sts = ST_ADDR;
                    else if (r_sp == '0) sts = ST_UNDER;
                    else begin
                        do_st  = 1'b1;
                        do_pop = 1'b1;
                    end
                end
                K_LDC: begin
                    if (sp_full) sts = ST_OVER;
                    else do_push = 1'b1;
                end
                K_ALU: begin
                    if (r_sp < SPW'(2)) sts = ST_UNDER;
                    else do_alu = 1'b1;
                end
                K_JMP: nxt = 11'(r_cur.target);
                K_BR: begin
                    if (r_sp == '0) sts = ST_UNDER;
                    else begin
                        do_pop = 1'b1;
                        if (r_tos != '0) nxt = 11'(r_cur.target);
                    end
                end
                K_HLT: sts = ST_HALT;
                default: sts = ST_RUN;
            endcase
            if (sts != ST_RUN) begin
                err = 1'b1;
                nxt = 11'(r_cur.pc);
            end else if (32'(nxt) >= lim) begin
                sts = ST_END;
            end
        end
    end

    assign commit = exec_go && !r_stopped && !err;

    always_comb begin
        n_sp  = r_sp;
        n_tos = r_tos;
        if (commit) begin
            if (do_push) begin
                n_sp  = r_sp + SPW'(1);
                n_tos = push_val;
            end else if (do_pop) begin
                n_sp  = sp_m1;
                n_tos = r_smem_q;
            end else if (do_alu) begin
                n_sp  = sp_m1;
                n_tos = alu_res;
            end
        end
    end

    assign smem_we = commit && do_push && (r_sp != '0);
    assign dmem_we = r_clr_busy || (commit && do_st);
    assign dmem_wa = r_clr_busy ? r_clr_idx : r_cur.value[DAW-1:0];
    assign dmem_wd = r_clr_busy ? 32'd0 : r_tos;

    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            r_dmem[dmem_wa] <= dmem_wd;
        end
        if (issue_go) begin
            r_dmem_q <= r_dmem[i_q_item.value[DAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (smem_we) begin
            r_smem[sp_m1[SAW-1:0]] <= r_tos;
        end
        if (issue_go) begin
            r_smem_q <= r_smem[sp_m2[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_go) begin
            r_cur <= i_q_item;
        end
        r_tos <= n_tos;
        if (exec_go) begin
            r_out.next_pc     <= nxt;
            r_out.status      <= sts;
            r_out.top_value   <= (n_sp == '0) ? 32'd0 : n_tos;
            r_out.stack_count <= 9'(n_sp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EX_ISSUE;
            r_sp        <= '0;
            r_stopped   <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (exec_go && (sts != ST_RUN)) begin
                r_stopped <= 1'b1;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + DAW'(1);
                if (r_clr_idx == DAW'(DATA_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

### sv/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: config register, front, queue, back.
// Depends on sme_pkg, sme_chan_if, sme_front, sme_queue, sme_back and the assert header.
`default_nettype none
`include "stack_machine_execute_unit_assert.svh"

// Executes one fetched stack-machine instruction per input beat and returns one
// result beat (next pc, status, top of stack, depth). The back-end sequencer
// reads the stack and data RAMs in its issue state and writes them in its
// exec state, taking no new instruction until the last one has executed; the
// front end and a two-entry queue keep taking beats while results wait. A
// beat passes the queue, the issue state and the exec state to the result
// register. After reset the data RAM is cleared one word a cycle, all DATA_DEPTH
// words (1024 by default), during which no instruction is accepted. program_length
// sits at byte address 0; write it only while no instruction is in flight.
module stack_machine_execute_unit #(
    parameter int DATA_DEPTH  = 1024,
    parameter int STACK_DEPTH = 256,
    parameter int PROG_DEPTH  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sme_in_if.sink      i_cmd,
    sme_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sme_pkg::*;

    logic [10:0] r_prog_len;
    logic        cfg_wr;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        clr_busy;
    t_dec_item   f_item;
    t_dec_item   q_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {21'd0, r_prog_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= 11'd0;
        end else if (cfg_wr) begin
            r_prog_len <= pwdata[10:0];
        end
    end

    sme_front #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_front (
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .i_hold   (clr_busy),
        .o_push   (push),
        .o_item   (f_item)
    );

    sme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    sme_back #(
        .DATA_DEPTH  (DATA_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .PROG_DEPTH  (PROG_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_prog_len (r_prog_len),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_clr_busy (clr_busy),
        .o_res      (o_res)
    );

    `SME_ASSERT_NOW(a_no_push_full, push, !q_full, "push into full queue")
    `SME_ASSERT_NOW(a_no_pop_empty, q_pop, q_valid, "pop from empty queue")
    `SME_ASSERT_NOW(a_hold_in_clear, clr_busy, !i_cmd.ready, "beat taken during clear")
    `SME_ASSERT_NEXT(a_clear_once, !clr_busy, !clr_busy, "clear pass restarted")

endmodule

`default_nettype wire
